// ===== sv/vnorm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_pkg
// Widths and constants shared by the vector normalisation pipeline.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  localparam int COMP_W     = 16;   // component and unit field width
  localparam int MAG_W      = 17;   // magnitude of a 16-bit signed value
  localparam int SQ_W       = 31;   // square of a magnitude, up to 2^30
  localparam int SUM_W      = 33;   // sum of up to four squares
  localparam int ACC_W      = 64;   // remainder and partial product width
  localparam int Q_W        = 15;   // quotient magnitude bits
  localparam int FRAC_SHIFT = 30;   // 2^30 scaling of the squared component
  localparam int NUM_LANES  = 4;
  localparam int LANE_STEPS = 15;   // one quotient bit per stage

endpackage

// ===== sv/vnorm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_in_if / vnorm_out_if
// Valid/ready channels carrying the input vector and the unit vector.
// ----------------------------------------------------------------------------
interface vnorm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] comp_x;
  logic signed [15:0] comp_y;
  logic signed [15:0] comp_z;
  logic signed [15:0] comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vnorm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic signed [15:0] unit_w;
  logic               zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, zero_length, output ready);
endinterface

// ===== sv/vnorm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_lane
// Pipelined restoring search for the largest q with q*q*S <= m*m*2^30,
// one quotient bit per register stage, shift-and-add only.
// ----------------------------------------------------------------------------
module vnorm_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vnorm_pkg::SQ_W-1:0]   m_sq,
  input  logic [vnorm_pkg::SUM_W-1:0]  sum_sq,
  output logic [vnorm_pkg::Q_W-1:0]    q
);
  import vnorm_pkg::*;

  logic [ACC_W-1:0] rem  [LANE_STEPS+1];
  logic [ACC_W-1:0] prod [LANE_STEPS+1];   // q * S so far
  logic [SUM_W-1:0] sums [LANE_STEPS+1];
  logic [Q_W-1:0]   qs   [LANE_STEPS+1];

  assign rem[0]  = {{(ACC_W-SQ_W-FRAC_SHIFT){1'b0}}, m_sq, {FRAC_SHIFT{1'b0}}};
  assign prod[0] = '0;
  assign sums[0] = sum_sq;
  assign qs[0]   = '0;

  for (genvar k = 0; k < LANE_STEPS; k++) begin : g_step
    localparam int B = LANE_STEPS - 1 - k;
    logic [ACC_W-1:0] s_wide;
    logic [ACC_W-1:0] delta;
    logic             take;

    // (q + 2^b)^2 S - q^2 S = q S 2^(b+1) + S 2^(2b)
    assign s_wide = {{(ACC_W-SUM_W){1'b0}}, sums[k]};
    assign delta  = (prod[k] << (B + 1)) + (s_wide << (2 * B));
    assign take   = (delta <= rem[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        sums[k+1] <= sums[k];
        if (take) begin
          rem[k+1]  <= rem[k] - delta;
          prod[k+1] <= prod[k] + (s_wide << B);
          qs[k+1]   <= qs[k] | Q_W'(1 << B);
        end else begin
          rem[k+1]  <= rem[k];
          prod[k+1] <= prod[k];
          qs[k+1]   <= qs[k];
        end
      end
    end
  end

  assign q = qs[LANE_STEPS];

endmodule

// ===== sv/vector_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize
// Scales a vector of signed 16-bit components to unit length in Q1.15.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   comp_x comp_y comp_z comp_w
//  results   out  valid/ready   unit_x unit_y unit_z unit_w zero_length
//
//  one vector per cycle unless the output stalls; stages: magnitude, square,
//  sum, fifteen quotient-bit stages per lane, sign and output register
//  the pipeline advances as a whole while the output is empty or taken
//  rst clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
module vector_normalize #(
  parameter int DIMENSION = 3
) (
  input  logic  clk,
  input  logic  rst,
  vnorm_in_if.sink    samples,
  vnorm_out_if.source results
);
  import vnorm_pkg::*;

  localparam int DIMS  = (DIMENSION < 2) ? 2 : ((DIMENSION > 4) ? 4 : DIMENSION);
  localparam int DEPTH = LANE_STEPS + 1;   // lane stages plus output stage

  logic advance;
  logic v1, v2, v3;
  logic vpipe [DEPTH];

  logic [MAG_W-1:0]  mag1 [NUM_LANES];
  logic              neg1 [NUM_LANES];
  logic [SQ_W-1:0]   sq2  [NUM_LANES];
  logic              neg2 [NUM_LANES];
  logic [SQ_W-1:0]   sq3  [NUM_LANES];
  logic [SUM_W-1:0]  sum3;
  logic [NUM_LANES-1:0] negp [LANE_STEPS+1];
  logic              zerop [LANE_STEPS+1];
  logic [Q_W-1:0]    lane_q [NUM_LANES];
  logic [COMP_W-1:0] unit_r [NUM_LANES];
  logic              zero_r;
  logic signed [COMP_W-1:0] comps [NUM_LANES];

  assign advance       = !vpipe[DEPTH-1] || results.ready;
  assign samples.ready = advance;

  assign comps[0] = samples.comp_x;
  assign comps[1] = samples.comp_y;
  assign comps[2] = samples.comp_z;
  assign comps[3] = samples.comp_w;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i < DEPTH; i++) vpipe[i] <= 1'b0;
    end else if (advance) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
      vpipe[0] <= v3;
      for (int i = 1; i < DEPTH; i++) vpipe[i] <= vpipe[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        neg1[i] <= comps[i][COMP_W-1];
        mag1[i] <= comps[i][COMP_W-1] ? (MAG_W'(0) - MAG_W'(comps[i]))
                                      : MAG_W'(comps[i]);
        sq2[i]  <= SQ_W'(mag1[i] * mag1[i]);
        neg2[i] <= neg1[i];
        sq3[i]  <= sq2[i];
      end
      sum3 <= SUM_W'(sq2[0]) + SUM_W'(sq2[1])
            + ((DIMS > 2) ? SUM_W'(sq2[2]) : SUM_W'(0))
            + ((DIMS > 3) ? SUM_W'(sq2[3]) : SUM_W'(0));
      for (int i = 0; i < NUM_LANES; i++) negp[0][i] <= neg2[i];
      zerop[0] <= ((sq2[0] | sq2[1]
                  | ((DIMS > 2) ? sq2[2] : SQ_W'(0))
                  | ((DIMS > 3) ? sq2[3] : SQ_W'(0))) == '0);
      for (int k = 1; k <= LANE_STEPS; k++) begin
        negp[k]  <= negp[k-1];
        zerop[k] <= zerop[k-1];
      end
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    vnorm_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .m_sq   (sq3[i]),
      .sum_sq (sum3),
      .q      (lane_q[i])
    );

    always_ff @(posedge clk) begin
      if (advance) begin
        if (i >= DIMS || zerop[LANE_STEPS]) begin
          unit_r[i] <= '0;
        end else if (negp[LANE_STEPS][i]) begin
          unit_r[i] <= COMP_W'(0) - COMP_W'(lane_q[i]);
        end else begin
          unit_r[i] <= COMP_W'(lane_q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) zero_r <= zerop[LANE_STEPS];
  end

  assign results.valid       = vpipe[DEPTH-1];
  assign results.unit_x      = unit_r[0];
  assign results.unit_y      = unit_r[1];
  assign results.unit_z      = unit_r[2];
  assign results.unit_w      = unit_r[3];
  assign results.zero_length = zero_r;

endmodule

// ===== sv/vnorm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_checker
// Port-level checks on the normaliser output, bound to the top level.
// ----------------------------------------------------------------------------
module vnorm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] unit_x,
  input logic [15:0] unit_y,
  input logic [15:0] unit_z,
  input logic [15:0] unit_w,
  input logic        zero_length
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
      && $stable(unit_z) && $stable(unit_w) && $stable(zero_length))
    else $error("stalled result changed");

  // zero vector gives all zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |-> unit_x == 16'd0 && unit_y == 16'd0
      && unit_z == 16'd0 && unit_w == 16'd0)
    else $error("zero vector with nonzero unit field");

  // magnitude is capped below one
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_x != 16'h8000 && unit_y != 16'h8000
      && unit_z != 16'h8000 && unit_w != 16'h8000)
    else $error("unit field reached minus one");

  // a nonzero vector has a nonzero x or y or further field
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_length |-> (unit_x | unit_y | unit_z | unit_w) != 16'd0)
    else $error("nonzero vector gave all zeros");

endmodule

bind vector_normalize vnorm_checker u_vnorm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .unit_x      (results.unit_x),
  .unit_y      (results.unit_y),
  .unit_z      (results.unit_z),
  .unit_w      (results.unit_w),
  .zero_length (results.zero_length)
);
